// File: design/cbs_pkg.sv
// ============================================================================
// cbs_pkg
// Shared types, constants and small tables of the cubic B-spline smoother.
// ============================================================================
package cbs_pkg;

    // Width of the samples-per-segment register
    localparam int CFG_W = 4;

    // Samples-per-segment value after reset
    localparam logic [CFG_W-1:0] SPS_RESET = 4'd4;

    // Segment numbers along the clamped window pattern sequence
    localparam logic [2:0] SEG_FIRST_START = 3'd0;
    localparam logic [2:0] SEG_BODY        = 3'd3;
    localparam logic [2:0] SEG_TAIL_LAST   = 3'd6;

    // Window slot that holds the newest point
    localparam logic [1:0] SLOT_NEWEST = 2'd3;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_PASS,
        SEQ_START_X,
        SEQ_WAIT_X,
        SEQ_START_Y,
        SEQ_WAIT_Y,
        SEQ_EMIT,
        SEQ_FINAL
    } seq_state_t;

    typedef enum logic [2:0] {
        SU_IDLE,
        SU_LOAD,
        SU_MUL,
        SU_ACC,
        SU_PREP,
        SU_DIV,
        SU_DONE
    } su_state_t;

    // Integer basis numerator of term k at sample j of a segment with s samples
    function automatic logic [15:0] basis_num(input logic [CFG_W-1:0] s,
                                              input logic [CFG_W-1:0] j,
                                              input logic [1:0] k);
        int si;
        int ji;
        int ui;
        int val;
        si = int'(s);
        ji = int'(j);
        ui = si - ji;
        case (k)
            2'd0:    val = ui * ui * ui;
            2'd1:    val = 3 * ji * ji * ji - 6 * ji * ji * si + 4 * si * si * si;
            2'd2:    val = -3 * ji * ji * ji + 3 * ji * ji * si + 3 * ji * si * si
                           + si * si * si;
            default: val = ji * ji * ji;
        endcase
        return 16'(val);
    endfunction

    // Common denominator 6*s^3
    function automatic logic [15:0] den_num(input logic [CFG_W-1:0] s);
        int si;
        si = int'(s);
        return 16'(6 * si * si * si);
    endfunction

    // Window slot used by term t of segment seg: the sequence 0,0,0,0,1,2,3,3,3,3
    function automatic logic [1:0] seg_index(input logic [2:0] seg, input logic [1:0] t);
        logic [3:0] p;
        logic [3:0] q;
        p = {1'b0, seg} + {2'b00, t};
        q = p - 4'd3;
        if (p <= 4'd3) begin
            return 2'd0;
        end else if (p >= 4'd6) begin
            return 2'd3;
        end else begin
            return q[1:0];
        end
    endfunction

endpackage

// File: design/cbs_sample_unit.sv
// ============================================================================
// cbs_sample_unit
// One coordinate of one curve sample: four multiply-accumulate steps through
// a shared multiplier, then round-to-nearest division by 6*s^3 with a
// restoring divider that retires one quotient bit per cycle.
// ============================================================================
module cbs_sample_unit
    import cbs_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int DEN_W       = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [CFG_W-1:0]              s,
    input  logic [CFG_W-1:0]              j,
    output logic [1:0]                    term,
    input  logic signed [COORD_WIDTH-1:0] operand,
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] result
);

    localparam int ACC_W = COORD_WIDTH + DEN_W + 1;
    localparam int MAG_W = COORD_WIDTH + DEN_W;
    localparam int CNT_W = $clog2(COORD_WIDTH);

    su_state_t state_reg, state_next;

    logic [1:0]                    term_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [DEN_W-1:0]              coef_reg;
    logic signed [COORD_WIDTH-1:0] opnd_reg;
    logic signed [ACC_W-1:0]       prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic [DEN_W-1:0]              den_reg;
    logic [DEN_W-1:0]              rem_reg;
    logic [COORD_WIDTH-1:0]        dvd_reg;
    logic                          neg_reg;

    logic [15:0]             coef_full;
    logic [15:0]             den_full;
    logic signed [ACC_W-1:0] mul_a;
    logic signed [ACC_W-1:0] mul_b;
    logic signed [ACC_W-1:0] prod;
    logic [ACC_W-1:0]        acc_abs;
    logic [MAG_W-1:0]        mag;
    logic [DEN_W:0]          trial;
    logic [DEN_W:0]          trial_sub;
    logic                    ge;
    logic [DEN_W-1:0]        rem_next;

    // Basis coefficient and denominator lookup
    assign coef_full = basis_num(s, j, term_reg);
    assign den_full  = den_num(s);

    // Multiplier operands widened to the accumulator width
    assign mul_a = signed'({{(ACC_W - DEN_W){1'b0}}, coef_reg});
    assign mul_b = signed'({{(ACC_W - COORD_WIDTH){opnd_reg[COORD_WIDTH-1]}}, opnd_reg});
    assign prod  = mul_a * mul_b;

    // Magnitude plus half the denominator for rounding away from zero
    assign acc_abs = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign mag     = acc_abs[MAG_W-1:0] + MAG_W'(den_reg >> 1);

    // Restoring divide step
    assign trial     = {rem_reg, dvd_reg[COORD_WIDTH-1]};
    assign ge        = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};
    assign rem_next  = ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SU_IDLE:
            begin
                if (start)
                begin
                    state_next = SU_LOAD;
                end
            end
            SU_LOAD: state_next = SU_MUL;
            SU_MUL:  state_next = SU_ACC;
            SU_ACC:
            begin
                if (term_reg == 2'd3)
                begin
                    state_next = SU_PREP;
                end
                else
                begin
                    state_next = SU_LOAD;
                end
            end
            SU_PREP: state_next = SU_DIV;
            SU_DIV:
            begin
                if (cnt_reg == CNT_W'(COORD_WIDTH - 1))
                begin
                    state_next = SU_DONE;
                end
            end
            SU_DONE: state_next = SU_IDLE;
            default: state_next = SU_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        term   = term_reg;
        done   = (state_reg == SU_DONE);
        result = neg_reg ? signed'(~dvd_reg + 1'b1) : signed'(dvd_reg);
    end

    // Sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SU_IDLE;
            term_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == SU_IDLE && start)
            begin
                term_reg <= '0;
            end
            if (state_reg == SU_ACC)
            begin
                term_reg <= term_reg + 1'b1;
            end
            if (state_reg == SU_PREP)
            begin
                cnt_reg <= '0;
            end
            if (state_reg == SU_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            SU_IDLE:
            begin
                if (start)
                begin
                    den_reg <= den_full[DEN_W-1:0];
                    acc_reg <= '0;
                end
            end
            SU_LOAD:
            begin
                coef_reg <= coef_full[DEN_W-1:0];
                opnd_reg <= operand;
            end
            SU_MUL:
            begin
                prod_reg <= prod;
            end
            SU_ACC:
            begin
                acc_reg <= acc_reg + prod_reg;
            end
            SU_PREP:
            begin
                neg_reg <= acc_reg[ACC_W-1];
                rem_reg <= mag[MAG_W-1:COORD_WIDTH];
                dvd_reg <= mag[COORD_WIDTH-1:0];
            end
            SU_DIV:
            begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[COORD_WIDTH-2:0], ge};
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: design/cubic_bspline_path_smoother.sv
// ============================================================================
// cubic_bspline_path_smoother
// Uniform cubic B-spline sampling of a stream of 2-D control points, with
// both path ends clamped and the exact final point appended.
// ============================================================================
// The block holds a four-point window and takes one control point at a time;
// in_ready is low while the results of a point are being produced. Every
// curve sample goes through one shared multiply-accumulate and one restoring
// divider, x and then y, with four multiply-accumulate steps and one
// quotient bit per cycle for each coordinate. A point causes S samples
// in steady flow, 4*S at the fourth point of a path, and 3*S more plus the
// final point at the path end. The first three points are only stored in the
// window; a passed-through point emits the buffered points and then itself.
// A finished item waits while the output register is still full and not
// being taken. Finished items sit in an output register, so the next sample
// is already being computed while one waits to be taken. Values of the
// samples-per-segment setting above MAX_SAMPLES act as MAX_SAMPLES.
// ============================================================================
module cubic_bspline_path_smoother
    import cbs_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int MAX_SAMPLES = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [CFG_W-1:0]              cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic                          path_end,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] sample_x,
    output logic signed [COORD_WIDTH-1:0] sample_y,
    output logic                          run_last,
    output logic                          path_done
);

    localparam int MAX_DEN = 6 * MAX_SAMPLES * MAX_SAMPLES * MAX_SAMPLES;
    localparam int DEN_W   = $clog2(MAX_DEN + 1);

    seq_state_t state_reg, state_next;

    logic [2:0]                    seen_reg;
    logic [CFG_W-1:0]              sps_reg;
    logic [CFG_W-1:0]              s_reg;
    logic [CFG_W-1:0]              j_reg;
    logic [2:0]                    seg_reg;
    logic [2:0]                    seg_last_reg;
    logic [1:0]                    pass_cnt_reg;
    logic [1:0]                    pass_idx_reg;
    logic                          end_reg;
    logic signed [COORD_WIDTH-1:0] cur_x_reg;
    logic signed [COORD_WIDTH-1:0] cur_y_reg;
    logic signed [COORD_WIDTH-1:0] win_x_reg [4];
    logic signed [COORD_WIDTH-1:0] win_y_reg [4];
    logic signed [COORD_WIDTH-1:0] x_res_reg;
    logic signed [COORD_WIDTH-1:0] y_res_reg;
    logic                          out_valid_reg;
    logic signed [COORD_WIDTH-1:0] sample_x_reg;
    logic signed [COORD_WIDTH-1:0] sample_y_reg;
    logic                          run_last_reg;
    logic                          path_done_reg;

    logic                          accept;
    logic [CFG_W-1:0]              s_sat;
    logic                          pass_mode;
    logic                          seen_full;
    logic                          starts_curve;
    logic                          slot_free;
    logic                          last_j;
    logic                          last_sample;
    logic                          su_start;
    logic                          su_done;
    logic [1:0]                    su_term;
    logic signed [COORD_WIDTH-1:0] su_result;
    logic signed [COORD_WIDTH-1:0] su_operand;
    logic                          coord_y;
    logic [1:0]                    rd_idx;
    logic signed [COORD_WIDTH-1:0] rd_x;
    logic signed [COORD_WIDTH-1:0] rd_y;
    logic                          emit;
    logic signed [COORD_WIDTH-1:0] emit_x;
    logic signed [COORD_WIDTH-1:0] emit_y;
    logic                          emit_last;
    logic                          emit_done;

    // Decode the incoming item
    assign accept       = in_valid && in_ready;
    assign s_sat        = (sps_reg > CFG_W'(MAX_SAMPLES)) ? CFG_W'(MAX_SAMPLES) : sps_reg;
    assign seen_full    = (seen_reg == 3'd4);
    assign starts_curve = seen_full || (seen_reg == 3'd3);
    assign pass_mode    = (s_sat == '0) || (path_end && (seen_reg < 3'd3));
    assign slot_free    = !out_valid_reg || out_ready;
    assign last_j       = (j_reg == s_reg - 1'b1);
    assign last_sample  = last_j && (seg_reg == seg_last_reg);

    // Window read port and operand for the shared unit
    assign rd_x       = win_x_reg[rd_idx];
    assign rd_y       = win_y_reg[rd_idx];
    assign su_operand = coord_y ? rd_y : rd_x;

    cbs_sample_unit #(
        .COORD_WIDTH (COORD_WIDTH),
        .DEN_W       (DEN_W)
    ) u_sample (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (su_start),
        .s       (s_reg),
        .j       (j_reg),
        .term    (su_term),
        .operand (su_operand),
        .done    (su_done),
        .result  (su_result)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    if (pass_mode)
                    begin
                        state_next = SEQ_PASS;
                    end
                    else if (starts_curve)
                    begin
                        state_next = SEQ_START_X;
                    end
                end
            end
            SEQ_PASS:
            begin
                if (slot_free && (pass_idx_reg == pass_cnt_reg))
                begin
                    state_next = SEQ_IDLE;
                end
            end
            SEQ_START_X: state_next = SEQ_WAIT_X;
            SEQ_WAIT_X:
            begin
                if (su_done)
                begin
                    state_next = SEQ_START_Y;
                end
            end
            SEQ_START_Y: state_next = SEQ_WAIT_Y;
            SEQ_WAIT_Y:
            begin
                if (su_done)
                begin
                    state_next = SEQ_EMIT;
                end
            end
            SEQ_EMIT:
            begin
                if (slot_free)
                begin
                    if (!last_sample)
                    begin
                        state_next = SEQ_START_X;
                    end
                    else if (end_reg)
                    begin
                        state_next = SEQ_FINAL;
                    end
                    else
                    begin
                        state_next = SEQ_IDLE;
                    end
                end
            end
            SEQ_FINAL:
            begin
                if (slot_free)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        in_ready  = 1'b0;
        su_start  = 1'b0;
        coord_y   = 1'b0;
        rd_idx    = seg_index(seg_reg, su_term);
        emit      = 1'b0;
        emit_x    = x_res_reg;
        emit_y    = y_res_reg;
        emit_last = 1'b0;
        emit_done = 1'b0;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                in_ready = 1'b1;
            end
            SEQ_PASS:
            begin
                rd_idx = pass_idx_reg;
                emit   = slot_free;
                if (pass_idx_reg == pass_cnt_reg)
                begin
                    emit_x    = cur_x_reg;
                    emit_y    = cur_y_reg;
                    emit_last = 1'b1;
                    emit_done = end_reg;
                end
                else
                begin
                    emit_x = rd_x;
                    emit_y = rd_y;
                end
            end
            SEQ_START_X:
            begin
                su_start = 1'b1;
            end
            SEQ_WAIT_X:
            begin
            end
            SEQ_START_Y:
            begin
                su_start = 1'b1;
                coord_y  = 1'b1;
            end
            SEQ_WAIT_Y:
            begin
                coord_y = 1'b1;
            end
            SEQ_EMIT:
            begin
                emit      = slot_free;
                emit_last = last_sample && !end_reg;
            end
            SEQ_FINAL:
            begin
                rd_idx    = SLOT_NEWEST;
                emit      = slot_free;
                emit_x    = rd_x;
                emit_y    = rd_y;
                emit_last = 1'b1;
                emit_done = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            seen_reg      <= '0;
            sps_reg       <= SPS_RESET;
            out_valid_reg <= 1'b0;
            pass_idx_reg  <= '0;
            seg_reg       <= '0;
            j_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // Take a configuration write
            if (cfg_wr_en)
            begin
                sps_reg <= cfg_wr_data;
            end

            // Start a new item and advance the point count
            if (accept)
            begin
                pass_idx_reg <= '0;
                j_reg        <= '0;
                seg_reg      <= seen_full ? SEG_BODY : SEG_FIRST_START;
                if (pass_mode || path_end)
                begin
                    seen_reg <= '0;
                end
                else if (!seen_full)
                begin
                    seen_reg <= seen_reg + 3'd1;
                end
            end

            // Step through buffered points
            if (state_reg == SEQ_PASS && slot_free)
            begin
                pass_idx_reg <= pass_idx_reg + 1'b1;
            end

            // Step through samples and segments
            if (state_reg == SEQ_EMIT && slot_free)
            begin
                if (last_j)
                begin
                    j_reg   <= '0;
                    seg_reg <= seg_reg + 3'd1;
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end

            // Hold the output item until it is taken
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: item fields, window, results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_reg        <= s_sat;
            end_reg      <= path_end;
            seg_last_reg <= path_end ? SEG_TAIL_LAST : SEG_BODY;
            pass_cnt_reg <= seen_full ? 2'd0 : seen_reg[1:0];
            cur_x_reg    <= point_x;
            cur_y_reg    <= point_y;
            if (!pass_mode)
            begin
                if (seen_full)
                begin
                    // Shift the window and append the new point
                    for (int i = 0; i < 3; i++)
                    begin
                        win_x_reg[i] <= win_x_reg[i + 1];
                        win_y_reg[i] <= win_y_reg[i + 1];
                    end
                    win_x_reg[SLOT_NEWEST] <= point_x;
                    win_y_reg[SLOT_NEWEST] <= point_y;
                end
                else
                begin
                    win_x_reg[seen_reg[1:0]] <= point_x;
                    win_y_reg[seen_reg[1:0]] <= point_y;
                end
            end
        end

        if (state_reg == SEQ_WAIT_X && su_done)
        begin
            x_res_reg <= su_result;
        end
        if (state_reg == SEQ_WAIT_Y && su_done)
        begin
            y_res_reg <= su_result;
        end

        // Load the output register
        if (emit)
        begin
            sample_x_reg  <= emit_x;
            sample_y_reg  <= emit_y;
            run_last_reg  <= emit_last;
            path_done_reg <= emit_done;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample_x  = sample_x_reg;
    assign sample_y  = sample_y_reg;
    assign run_last  = run_last_reg;
    assign path_done = path_done_reg;

endmodule
